### hw/rtl/utf8_to_utf16_converter_macros.svh
// Assertion macros shared by the converter RTL.
`ifndef UTF8_TO_UTF16_CONVERTER_MACROS_SVH
`define UTF8_TO_UTF16_CONVERTER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define U8U16_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define U8U16_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/u8u16_pkg.sv
// Types and constants of the UTF-8 to UTF-16 converter.
package u8u16_pkg;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_LIMIT   = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  typedef enum logic {
    OP_DATA = 1'b0,
    OP_END  = 1'b1
  } op_t;

  localparam logic [10:0] MAX_UNITS_RESET = 11'd670;

  // Lead byte ranges
  localparam logic [7:0] LEAD2_LO = 8'hC2;
  localparam logic [7:0] LEAD2_HI = 8'hDF;
  localparam logic [7:0] LEAD3_LO = 8'hE0;
  localparam logic [7:0] LEAD3_HI = 8'hEF;
  localparam logic [7:0] LEAD4_LO = 8'hF0;
  localparam logic [7:0] LEAD4_HI = 8'hF4;
  localparam logic [1:0] CONT_TAG = 2'b10;

  // Code point limits
  localparam logic [20:0] CP_MIN2     = 21'h000080;
  localparam logic [20:0] CP_MIN3     = 21'h000800;
  localparam logic [20:0] CP_MIN4     = 21'h010000;
  localparam logic [20:0] CP_MAX      = 21'h10FFFF;
  localparam logic [20:0] CP_SURR_LO  = 21'h00D800;
  localparam logic [20:0] CP_SURR_HI  = 21'h00DFFF;
  localparam logic [15:0] HI_SURR_BASE = 16'hD800;
  localparam logic [15:0] LO_SURR_BASE = 16'hDC00;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        is_status;
    status_t     status;
    logic [10:0] unit_count;
    logic        last;
  } res_t;

  // Results produced by one item: count 0..2, then the two slots in order
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

### hw/rtl/u8u16_core.sv
// Message state and per-byte decode of the converter.
`include "utf8_to_utf16_converter_macros.svh"

module u8u16_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  u8u16_pkg::item_t item,
  input  logic [10:0]      max_units,
  output u8u16_pkg::push_t push
);
  import u8u16_pkg::*;

  logic [20:0] partial_point, partial_point_next;
  logic [1:0]  bytes_pending, bytes_pending_next;
  logic [1:0]  sequence_extra, sequence_extra_next;
  logic [10:0] units_given, units_given_next;
  status_t     error_code, error_code_next;

  logic        finish;
  logic [20:0] cp;
  logic [1:0]  cp_extra;
  logic [20:0] assembled;
  logic        bad_point;
  logic        need2;
  logic [11:0] unit_sum;
  logic [20:0] offset;

  assign assembled = {partial_point[14:0], item.data[5:0]};

  always_comb begin
    partial_point_next  = partial_point;
    bytes_pending_next  = bytes_pending;
    sequence_extra_next = sequence_extra;
    units_given_next    = units_given;
    error_code_next     = error_code;
    push                = '0;
    finish              = 1'b0;
    cp                  = '0;
    cp_extra            = '0;
    bad_point           = 1'b0;
    need2               = 1'b0;
    unit_sum            = '0;
    offset              = '0;

    if (item.op == OP_END) begin
      // Status result: sticky error first, then a cut-off sequence, then empty
      push.n                = 2'd1;
      push.r0.is_status     = 1'b1;
      push.r0.unit_count    = units_given;
      push.r0.last          = 1'b1;
      if (error_code != ST_OK) begin
        push.r0.status = error_code;
      end else if (bytes_pending != 2'd0) begin
        push.r0.status = ST_INVALID;
      end else if (units_given == 11'd0) begin
        push.r0.status = ST_EMPTY;
      end else begin
        push.r0.status = ST_OK;
      end
      partial_point_next  = '0;
      bytes_pending_next  = '0;
      sequence_extra_next = '0;
      units_given_next    = '0;
      error_code_next     = ST_OK;
    end else if (error_code != ST_OK) begin
      // dropping until the end marker
    end else if (bytes_pending == 2'd0) begin
      if (!item.data[7]) begin
        finish   = 1'b1;
        cp       = {13'd0, item.data};
        cp_extra = 2'd0;
      end else if (item.data >= LEAD2_LO && item.data <= LEAD2_HI) begin
        partial_point_next  = {16'd0, item.data[4:0]};
        sequence_extra_next = 2'd1;
        bytes_pending_next  = 2'd1;
      end else if (item.data >= LEAD3_LO && item.data <= LEAD3_HI) begin
        partial_point_next  = {17'd0, item.data[3:0]};
        sequence_extra_next = 2'd2;
        bytes_pending_next  = 2'd2;
      end else if (item.data >= LEAD4_LO && item.data <= LEAD4_HI) begin
        partial_point_next  = {18'd0, item.data[2:0]};
        sequence_extra_next = 2'd3;
        bytes_pending_next  = 2'd3;
      end else begin
        error_code_next     = ST_INVALID;
        partial_point_next  = '0;
        bytes_pending_next  = '0;
        sequence_extra_next = '0;
      end
    end else if (item.data[7:6] != CONT_TAG) begin
      error_code_next     = ST_INVALID;
      partial_point_next  = '0;
      bytes_pending_next  = '0;
      sequence_extra_next = '0;
    end else if (bytes_pending == 2'd1) begin
      finish   = 1'b1;
      cp       = assembled;
      cp_extra = sequence_extra;
    end else begin
      partial_point_next = assembled;
      bytes_pending_next = bytes_pending - 2'd1;
    end

    if (finish) begin
      partial_point_next  = '0;
      bytes_pending_next  = '0;
      sequence_extra_next = '0;
      bad_point = (cp_extra == 2'd1 && cp < CP_MIN2) ||
                  (cp_extra == 2'd2 && cp < CP_MIN3) ||
                  (cp_extra == 2'd3 && cp < CP_MIN4) ||
                  (cp > CP_MAX) ||
                  (cp >= CP_SURR_LO && cp <= CP_SURR_HI);
      need2    = |cp[20:16];
      unit_sum = {1'b0, units_given} + (need2 ? 12'd2 : 12'd1);
      offset   = cp - CP_MIN4;
      if (bad_point) begin
        error_code_next = ST_INVALID;
      end else if (unit_sum > {1'b0, max_units}) begin
        error_code_next = ST_LIMIT;
      end else begin
        units_given_next = unit_sum[10:0];
        if (need2) begin
          push.n            = 2'd2;
          push.r0.code_unit = HI_SURR_BASE + {6'd0, offset[19:10]};
          push.r1.code_unit = LO_SURR_BASE + {6'd0, offset[9:0]};
          push.r1.last      = 1'b1;
        end else begin
          push.n            = 2'd1;
          push.r0.code_unit = cp[15:0];
          push.r0.last      = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_point  <= '0;
      bytes_pending  <= '0;
      sequence_extra <= '0;
      units_given    <= '0;
      error_code     <= ST_OK;
    end else if (fire) begin
      partial_point  <= partial_point_next;
      bytes_pending  <= bytes_pending_next;
      sequence_extra <= sequence_extra_next;
      units_given    <= units_given_next;
      error_code     <= error_code_next;
    end
  end

  `U8U16_ASSERT_NOW(a_pend_no_err, bytes_pending != 2'd0, error_code == ST_OK,
    "sequence pending while in error")
  `U8U16_ASSERT_NOW(a_pair_tags, fire && push.n == 2'd2,
    push.r0.code_unit[15:10] == 6'b110110 && push.r1.code_unit[15:10] == 6'b110111,
    "malformed surrogate pair")
  `U8U16_ASSERT_NEXT(a_end_clears, fire && item.op == OP_END,
    units_given == 11'd0 && error_code == ST_OK && bytes_pending == 2'd0,
    "message state not cleared after end marker")

endmodule

### hw/rtl/u8u16_res_queue.sv
// Four-entry result queue taking up to two results per cycle.
`include "utf8_to_utf16_converter_macros.svh"

module u8u16_res_queue (
  input  logic             clk,
  input  logic             rst,
  input  u8u16_pkg::push_t push,
  output logic             room,
  output logic             out_valid,
  input  logic             out_stall,
  output u8u16_pkg::res_t  out_res
);
  import u8u16_pkg::*;

  res_t       entries [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic       pop;

  assign room      = (count <= 3'd2);
  assign out_valid = (count != 3'd0);
  assign pop       = out_valid && !out_stall;
  assign out_res   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      entries[wr_ptr] <= push.r0;
    end
    if (push.n == 2'd2) begin
      entries[wr_ptr + 2'd1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push.n;
      rd_ptr <= rd_ptr + {1'b0, pop};
      count  <= count + {1'b0, push.n} - {2'b0, pop};
    end
  end

  `U8U16_ASSERT_NOW(a_no_overflow, push.n != 2'd0,
    ({1'b0, count} + {2'b0, push.n}) <= 4'd4, "result queue overflow")
  `U8U16_ASSERT_NEXT(a_hold_valid, out_valid && out_stall, out_valid,
    "output valid dropped while stalled")
  `U8U16_ASSERT_NEXT(a_hold_data, out_valid && out_stall, $stable(out_res),
    "output payload changed while stalled")

endmodule

### hw/rtl/utf8_to_utf16_converter.sv
// Top level of the UTF-8 to UTF-16 converter.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------------
//  in      | in        | in_valid / in_stall  | op, byte_in
//  out     | out       | out_valid / out_stall| code_unit, is_status, status,
//          |           |                      | unit_count, last
//  cfg     | in        | cfg_wr_en            | cfg_wr_data (max_units)
//
// One input transfer per cycle sustained while in_stall is low; a byte is held
// in the input register, is decoded and lands in a four-entry result queue. The
// first result is valid after the byte has been decoded and written to the queue.
// A surrogate pair pushes two results at once but needs four input bytes, so
// in_stall (byte held, queue at three or more) only rises under out_stall.
// rst is synchronous: clears message state, the queue and sets max_units to 670.
module utf8_to_utf16_converter (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op,
  input  logic [7:0]  byte_in,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] code_unit,
  output logic        is_status,
  output logic [1:0]  status,
  output logic [10:0] unit_count,
  output logic        last,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [10:0] cfg_wr_data
);
  import u8u16_pkg::*;

  logic [10:0] max_units;
  item_t       in_item;
  logic        in_full;
  logic        room;
  logic        fire;
  logic        in_take;
  push_t       push;
  push_t       push_gated;
  res_t        out_res;

  // Decode fires when a byte is held and the queue has space for a pair.
  assign fire     = in_full && room;
  assign in_stall = in_full && !room;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_units <= MAX_UNITS_RESET;
    end else if (cfg_wr_en) begin
      max_units <= cfg_wr_data;
    end
  end

  // Input register: payload unreset, full flag is control.
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item.op   <= op_t'(op);
      in_item.data <= byte_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_take) begin
      in_full <= 1'b1;
    end else if (fire) begin
      in_full <= 1'b0;
    end
  end

  u8u16_core u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .item      (in_item),
    .max_units (max_units),
    .push      (push)
  );

  // Gate pushes on fire so an idle decode never writes the queue.
  assign push_gated = fire ? push : '0;

  u8u16_res_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push_gated),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign code_unit  = out_res.code_unit;
  assign is_status  = out_res.is_status;
  assign status     = out_res.status;
  assign unit_count = out_res.unit_count;
  assign last       = out_res.last;

endmodule

### tb/sv/tb_utf8_to_utf16_converter.sv
// Self-checking testbench for the UTF-8 to UTF-16 converter.
`timescale 1ns / 1ps

module tb_utf8_to_utf16_converter;
  import u8u16_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  // first result waits on the input register and the result queue; leave margin
  localparam int SETTLE_CYCLES = 6;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        op;
  logic [7:0]  byte_in;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] code_unit;
  logic        is_status;
  logic [1:0]  status;
  logic [10:0] unit_count;
  logic        last;
  logic        cfg_wr_en;
  logic [10:0] cfg_wr_data;

  utf8_to_utf16_converter DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .byte_in    (byte_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .code_unit  (code_unit),
    .is_status  (is_status),
    .status     (status),
    .unit_count (unit_count),
    .last       (last),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Transcoder state mirrored on the testbench side
  // ---------------------------------------------------------------------------
  logic [10:0] unit_limit;    // max_units as last written
  logic [20:0] cp_acc;        // code point being assembled
  logic [1:0]  cont_left;     // continuation bytes still owed
  logic [1:0]  cont_total;    // continuation bytes in the current sequence
  logic [10:0] units_out;     // units emitted in this message
  status_t     msg_err;       // sticky error, ST_OK while clean

  res_t        utf16_results_q[$];  // units and status words still to come
  logic [7:0]  msg_bytes[$];        // bytes of the message being sent

  // Run bookkeeping
  int  cycle_count = 0;
  int  mismatch_count = 0;
  int  results_seen = 0;
  int  items_sent = 0;
  int  messages_sent = 0;
  int  limit_writes = 0;
  int  rx_hold = 0;
  bit  tx_quiet = 1'b0;  // sender runs back to back while set
  bit  rx_quiet = 1'b0;  // receiver never stalls while set
  res_t want_res;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------
  function automatic void queue_result(logic [15:0] unit_val, logic is_st, status_t st,
                                       logic [10:0] cnt, logic lst);
    res_t r;
    r.code_unit  = unit_val;
    r.is_status  = is_st;
    r.status     = st;
    r.unit_count = cnt;
    r.last       = lst;
    utf16_results_q.push_back(r);
  endfunction

  function automatic void flag_error(status_t st);
    msg_err    = st;
    cp_acc     = '0;
    cont_left  = '0;
    cont_total = '0;
  endfunction

  // Code point complete: range checks, limit check, then one unit or a pair.
  function automatic void close_point();
    logic [20:0] pt;
    logic [1:0]  ext;
    logic [19:0] off;
    int          need;
    pt         = cp_acc;
    ext        = cont_total;
    cp_acc     = '0;
    cont_left  = '0;
    cont_total = '0;
    need       = (pt > 21'h00FFFF) ? 2 : 1;
    if ((ext == 2'd1 && pt < CP_MIN2) || (ext == 2'd2 && pt < CP_MIN3) ||
        (ext == 2'd3 && pt < CP_MIN4) || pt > CP_MAX ||
        (pt >= CP_SURR_LO && pt <= CP_SURR_HI)) begin
      flag_error(ST_INVALID);
    end else if (int'(units_out) + need > int'(unit_limit)) begin
      flag_error(ST_LIMIT);
    end else begin
      if (need == 2) begin
        off = 20'(pt - CP_MIN4);
        queue_result(HI_SURR_BASE + 16'(off[19:10]), 1'b0, ST_OK, 11'd0, 1'b0);
        queue_result(LO_SURR_BASE + 16'(off[9:0]), 1'b0, ST_OK, 11'd0, 1'b1);
      end else begin
        queue_result(pt[15:0], 1'b0, ST_OK, 11'd0, 1'b1);
      end
      units_out = units_out + 11'(need);
    end
  endfunction

  // Advance the mirrored state by one accepted input transfer.
  function automatic void transcode_item(op_t kind, logic [7:0] data);
    status_t st;
    if (kind == OP_END) begin
      // priority: sticky error, then a cut-off sequence, then empty
      if (msg_err != ST_OK)     st = msg_err;
      else if (cont_left != 0)  st = ST_INVALID;
      else if (units_out == 0)  st = ST_EMPTY;
      else                      st = ST_OK;
      queue_result(16'h0000, 1'b1, st, units_out, 1'b1);
      flag_error(ST_OK);
      units_out = '0;
    end else if (msg_err == ST_OK) begin
      if (cont_left == 0) begin
        if (data < 8'h80) begin
          cp_acc     = 21'(data);
          cont_total = 2'd0;
          close_point();
        end else if (data >= LEAD2_LO && data <= LEAD2_HI) begin
          cp_acc = 21'(data[4:0]); cont_total = 2'd1; cont_left = 2'd1;
        end else if (data >= LEAD3_LO && data <= LEAD3_HI) begin
          cp_acc = 21'(data[3:0]); cont_total = 2'd2; cont_left = 2'd2;
        end else if (data >= LEAD4_LO && data <= LEAD4_HI) begin
          cp_acc = 21'(data[2:0]); cont_total = 2'd3; cont_left = 2'd3;
        end else begin
          flag_error(ST_INVALID);
        end
      end else if (data[7:6] != CONT_TAG) begin
        flag_error(ST_INVALID);
      end else begin
        cp_acc    = {cp_acc[14:0], data[5:0]};
        cont_left = cont_left - 2'd1;
        if (cont_left == 0) close_point();
      end
    end
    // bytes after an error fall through here: dropped, nothing expected
  endfunction

  // ---------------------------------------------------------------------------
  // Message building
  // ---------------------------------------------------------------------------
  function automatic int idle_cycles(bit quiet);
    return quiet ? 0 : int'($urandom_range(0, 17));
  endfunction

  // Encode pt with a forced length; lets overlong and out-of-range forms through.
  function automatic void put_seq(logic [20:0] pt, int len);
    case (len)
      1: msg_bytes.push_back(pt[7:0]);
      2: begin
        msg_bytes.push_back({3'b110, pt[10:6]});
        msg_bytes.push_back({CONT_TAG, pt[5:0]});
      end
      3: begin
        msg_bytes.push_back({4'b1110, pt[15:12]});
        msg_bytes.push_back({CONT_TAG, pt[11:6]});
        msg_bytes.push_back({CONT_TAG, pt[5:0]});
      end
      default: begin
        msg_bytes.push_back({5'b11110, pt[20:18]});
        msg_bytes.push_back({CONT_TAG, pt[17:12]});
        msg_bytes.push_back({CONT_TAG, pt[11:6]});
        msg_bytes.push_back({CONT_TAG, pt[5:0]});
      end
    endcase
  endfunction

  // Legal code point whose shortest form has len bytes.
  function automatic logic [20:0] random_point(int len);
    logic [20:0] pt;
    case (len)
      1:       pt = ($urandom_range(0, 15) == 0) ? 21'd0 : 21'($urandom_range(1, 'h7F));
      2:       pt = 21'($urandom_range('h80, 'h7FF));
      3: begin
        pt = 21'($urandom_range('h800, 'hFFFF));
        if (pt >= CP_SURR_LO && pt <= CP_SURR_HI) pt = pt ^ 21'h002000;
      end
      default: pt = 21'($urandom_range('h10000, 'h10FFFF));
    endcase
    return pt;
  endfunction

  function automatic void add_valid_point();
    int r;
    int len;
    r   = $urandom_range(0, 9);
    len = (r < 4) ? 1 : (r < 6) ? 2 : (r < 8) ? 3 : 4;  // pairs get a fair share
    put_seq(random_point(len), len);
  endfunction

  // One malformed fragment; a cut-off sequence only makes sense at the end.
  function automatic void add_fault(bit at_end);
    int         kind;
    int         len;
    int         idx;
    logic [7:0] b;
    kind = $urandom_range(0, at_end ? 6 : 5);
    len  = $urandom_range(2, 4);
    case (kind)
      0: begin  // lead byte that never starts a sequence
        b = $urandom_range(0, 1) ? 8'($urandom_range('h80, 'hC1))
                                 : 8'($urandom_range('hF5, 'hFF));
        msg_bytes.push_back(b);
      end
      1: begin  // continuation byte without the 10 tag
        put_seq(random_point(len), len);
        idx = msg_bytes.size() - int'($urandom_range(1, len - 1));
        b   = 8'($urandom_range(0, 255));
        if (b[7:6] == CONT_TAG) b[6] = 1'b1;
        msg_bytes[idx] = b;
      end
      2: put_seq(21'($urandom_range(0, len == 2 ? 'h7F : len == 3 ? 'h7FF : 'hFFFF)), len);
      3: put_seq(21'($urandom_range(CP_SURR_LO, CP_SURR_HI)), 3);
      4: put_seq(21'($urandom_range('h110000, 'h1FFFFF)), 4);
      5: repeat ($urandom_range(1, 4)) msg_bytes.push_back(8'($urandom_range(0, 255)));
      default: begin  // truncated sequence right before the end marker
        put_seq(random_point(len), len);
        repeat ($urandom_range(1, len - 1)) void'(msg_bytes.pop_back());
      end
    endcase
  endfunction

  // Mostly well-formed text; about a quarter of messages carry one fault.
  function automatic void build_random_message();
    int npts;
    int fault_at;
    msg_bytes.delete();
    npts     = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
    fault_at = ($urandom_range(0, 99) < 25) ? int'($urandom_range(0, npts)) : -1;
    for (int i = 0; i <= npts; i++) begin
      if (i == fault_at) add_fault(i == npts);
      if (i < npts) add_valid_point();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus primitives
  // ---------------------------------------------------------------------------
  // One input transfer. Valid stays high after acceptance so the next call can
  // go back to back; callers that let time pass lower it first.
  task automatic send_item(op_t kind, logic [7:0] data);
    int gap;
    gap = idle_cycles(tx_quiet);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= kind;
    byte_in  <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    transcode_item(kind, data);
    items_sent++;
  endtask

  task automatic send_message();
    foreach (msg_bytes[i]) send_item(OP_DATA, msg_bytes[i]);
    send_item(OP_END, 8'($urandom_range(0, 255)));  // byte field is don't-care here
    messages_sent++;
  endtask

  // Hold off input until every predicted result has been taken, then settle.
  task automatic wait_drained(int settle);
    in_valid <= 1'b0;
    while (utf16_results_q.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Register write, only with the converter idle.
  task automatic set_unit_limit(logic [10:0] value);
    wait_drained(SETTLE_CYCLES);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    unit_limit  = value;
    limit_writes++;
  endtask

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    mismatch_count++;
    $display("mismatch on %s at result %0d: got 0x%0h, expected 0x%0h",
             what, results_seen, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Length boundaries U+7F/U+80 and U+FFFF/U+10000, zero byte and both surrogate-pair ends.
  task automatic test_code_points();
    msg_bytes = '{8'h00, 8'h7F, 8'hC2, 8'h80, 8'hEF, 8'hBF, 8'hBF,
                  8'hF0, 8'h90, 8'h80, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
    send_message();
  endtask

  task automatic test_empty_message();
    msg_bytes.delete();
    send_message();
  endtask

  // Each way a message goes invalid, including bytes dropped after the fault.
  task automatic test_malformed();
    msg_bytes = '{8'hC0};                       send_message();  // bad lead
    msg_bytes = '{8'hE0, 8'h80, 8'h80};         send_message();  // overlong
    msg_bytes = '{8'hED, 8'hA0, 8'h80};         send_message();  // surrogate
    msg_bytes = '{8'hF4, 8'h90, 8'h80, 8'h80};  send_message();  // past U+10FFFF
    msg_bytes = '{8'h41, 8'hC3, 8'h41, 8'h42};  send_message();  // bad continuation
    msg_bytes = '{8'h41, 8'hE2, 8'h82};         send_message();  // cut off at end
  endtask

  // Limit after reset, before any write: 671st unit trips it.
  task automatic test_default_limit();
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    msg_bytes.delete();
    repeat (int'(MAX_UNITS_RESET) + 1) msg_bytes.push_back(8'($urandom_range(1, 'h7F)));
    send_message();
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  task automatic test_unit_limit_edges();
    set_unit_limit(11'd0);  // nothing fits
    msg_bytes = '{8'h41};
    send_message();
    set_unit_limit(11'd2);  // pair does not fit behind one unit
    msg_bytes = '{8'h41, 8'hF0, 8'h90, 8'h80, 8'h80, 8'h41};
    send_message();
    set_unit_limit(11'd1);  // limit error outranks the later cut-off lead
    msg_bytes = '{8'h41, 8'h41, 8'hE2};
    send_message();
  endtask

  // Bulk random text across several limit settings.
  task automatic test_random_traffic();
    int target;
    for (int p = 0; p < 6; p++) begin
      case (p)
        0:       set_unit_limit(11'd1);
        1:       set_unit_limit(11'd4);
        2:       set_unit_limit(11'd2047);
        3:       set_unit_limit(11'($urandom_range(2, 24)));
        4:       set_unit_limit(11'($urandom_range(1, 2047)));
        default: set_unit_limit(11'd12);
      endcase
      target = items_sent + 128;
      while (items_sent < target) begin
        tx_quiet = ($urandom_range(0, 5) == 0);
        rx_quiet = ($urandom_range(0, 5) == 0);
        build_random_message();
        send_message();
        if ($urandom_range(0, 19) == 0) wait_drained(0);  // let the output run dry
      end
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  // Fill a limit exactly, ending on a pair: count lands on the limit.
  task automatic test_full_count();
    set_unit_limit(11'd100);
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    msg_bytes.delete();
    repeat (98) msg_bytes.push_back(8'($urandom_range(1, 'h7F)));
    put_seq(random_point(4), 4);
    send_message();
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stall, then compare against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      rx_hold    = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (utf16_results_q.size() == 0) begin
          report_mismatch("unexpected result, code_unit", 32'(code_unit), 0);
        end else begin
          want_res = utf16_results_q.pop_front();
          if (code_unit !== want_res.code_unit)
            report_mismatch("code_unit", 32'(code_unit), 32'(want_res.code_unit));
          if (is_status !== want_res.is_status)
            report_mismatch("is_status", 32'(is_status), 32'(want_res.is_status));
          if (status !== want_res.status)
            report_mismatch("status", 32'(status), 32'(want_res.status));
          if (unit_count !== want_res.unit_count)
            report_mismatch("unit_count", 32'(unit_count), 32'(want_res.unit_count));
          if (last !== want_res.last)
            report_mismatch("last", 32'(last), 32'(want_res.last));
        end
        rx_hold = idle_cycles(rx_quiet);
      end else if (rx_hold != 0) begin
        rx_hold--;
      end
      out_stall <= (rx_hold != 0);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, utf16_results_q.size());
      $display("tb_utf8_to_utf16_converter: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    op          = OP_DATA;
    byte_in     = 8'h00;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    unit_limit  = MAX_UNITS_RESET;
    units_out   = '0;
    flag_error(ST_OK);
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_code_points();
    test_empty_message();
    test_malformed();
    test_default_limit();
    test_unit_limit_edges();
    test_random_traffic();
    test_full_count();

    wait_drained(SETTLE_CYCLES + 4);
    $display("covered %0d input transfers in %0d messages over %0d limit settings",
             items_sent, messages_sent, limit_writes);
    $display("checked %0d output transfers, %0d mismatches", results_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("tb_utf8_to_utf16_converter: clean");
    end else begin
      $display("tb_utf8_to_utf16_converter: errors");
    end
    $finish;
  end

endmodule
